// File: hdl/ttb_pkg.sv
// Shared types and constants for the timeout timer bank.
package ttb_pkg;

   localparam int SLOTS_DEFAULT      = 16;
   localparam int LIMIT_BITS_DEFAULT = 16;
   localparam int FLAG_BITS          = 16;
   localparam int INDEX_BITS         = 4;
   localparam int IN_LIMIT_BITS      = 16;
   localparam int TIME_BITS          = 32;
   localparam int DEFAULT_LIMIT      = 3;
   localparam int RESET_LIMIT        = 5;
   localparam int REQ_DATA_BITS      = 24;
   localparam int RSP_DATA_BITS      = 56;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_ADD     = 2'd1,
      CMD_REMOVE  = 2'd2,
      CMD_RESTART = 2'd3
   } command_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                     fire;
      command_type              command;
      logic [INDEX_BITS-1:0]    slot_index;
      logic [IN_LIMIT_BITS-1:0] limit;
      logic                     start_now;
   } cell_cmd_type;

   // what each cell reports back
   typedef struct packed {
      logic grant;
      logic remove_hit;
      logic expired_next;
   } cell_status_type;

endpackage

// File: hdl/ttb_cell.sv
// One timeout slot: valid, limit, counter, running and expired state.
module ttb_cell #(
   parameter int INDEX      = 0,
   parameter int LIMIT_BITS = ttb_pkg::LIMIT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ttb_pkg::cell_cmd_type     cmd,
   input  logic                      free_before,
   output logic                      free_through,
   output ttb_pkg::cell_status_type  status
);

   logic                  valid_ff,   valid_in;
   logic                  running_ff, running_in;
   logic                  expired_ff, expired_in;
   logic [LIMIT_BITS-1:0] limit_ff,   limit_in;
   logic [LIMIT_BITS:0]   counter_ff, counter_in;

   logic                  hit;
   logic                  grant;
   logic                  run;
   logic [LIMIT_BITS:0]   count_inc;
   logic [LIMIT_BITS-1:0] lim;

   // slots above the index range can never be addressed
   assign hit   = (int'(cmd.slot_index) == INDEX);
   assign grant = cmd.fire && (cmd.command == ttb_pkg::CMD_ADD) && !valid_ff && !free_before;
   assign free_through = free_before || !valid_ff;
   assign lim       = LIMIT_BITS'(cmd.limit);
   assign run       = running_ff || (counter_ff == '0);
   assign count_inc = counter_ff + (LIMIT_BITS+1)'(1);

   always_comb begin
      valid_in   = valid_ff;
      running_in = running_ff;
      expired_in = expired_ff;
      limit_in   = limit_ff;
      counter_in = counter_ff;
      if (cmd.fire) begin
         case (cmd.command)
            ttb_pkg::CMD_TICK: begin
               if (valid_ff && (limit_ff != '0) && run) begin
                  counter_in = count_inc;
                  if (count_inc > {1'b0, limit_ff}) begin
                     expired_in = 1'b1;
                     running_in = 1'b0;
                  end else begin
                     running_in = 1'b1;
                  end
               end
            end
            ttb_pkg::CMD_ADD: begin
               if (grant) begin
                  valid_in   = 1'b1;
                  limit_in   = (lim != '0) ? lim : LIMIT_BITS'(ttb_pkg::DEFAULT_LIMIT);
                  expired_in = 1'b0;
                  counter_in = {1'b0, lim};
                  running_in = cmd.start_now;
               end
            end
            ttb_pkg::CMD_REMOVE: begin
               if (hit && valid_ff) valid_in = 1'b0;
            end
            ttb_pkg::CMD_RESTART: begin
               if (hit) begin
                  counter_in = '0;
                  expired_in = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   assign status.grant        = grant;
   assign status.remove_hit   = cmd.fire && (cmd.command == ttb_pkg::CMD_REMOVE) && hit && valid_ff;
   assign status.expired_next = expired_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         running_ff <= 1'b0;
         expired_ff <= 1'b0;
         limit_ff   <= LIMIT_BITS'(ttb_pkg::RESET_LIMIT);
         counter_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         running_ff <= running_in;
         expired_ff <= expired_in;
         limit_ff   <= limit_in;
         counter_ff <= counter_in;
      end
   end

endmodule

// File: hdl/timeout_timer_bank_unit.sv
// Top level of the timeout timer bank: row of slot cells and result register.
// Result: registered, shown in the cycle after its command is accepted.
// Throughput: one command per cycle unless an unread result holds req_tready low;
// the free-slot search ripples through the cell row within that cycle, so its
// length grows with SLOTS. Reset: synchronous, active high; slots go invalid
// with limit 5 and the time count returns to zero.
module timeout_timer_bank_unit #(
   parameter int SLOTS      = ttb_pkg::SLOTS_DEFAULT,
   parameter int LIMIT_BITS = ttb_pkg::LIMIT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [3:0] slot_index, [19:4] limit, [20] start_now, [23:21] zero
   input  logic [ttb_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] command
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] ok, [4:1] slot_out, [20:5] expired_flags, [52:21] time_now, [55:53] zero
   output logic [ttb_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int FLAG_SLOTS = (SLOTS < ttb_pkg::FLAG_BITS) ? SLOTS : ttb_pkg::FLAG_BITS;

   ttb_pkg::cell_cmd_type    cmd;
   ttb_pkg::cell_status_type status [SLOTS];
   logic [SLOTS:0]           free_chain;
   logic                     accept;

   logic [ttb_pkg::INDEX_BITS-1:0] grant_index;
   logic                           remove_ok;
   logic [ttb_pkg::FLAG_BITS-1:0]  flags_next;
   logic                           ok_next;
   logic [ttb_pkg::INDEX_BITS-1:0] slot_next;

   logic [ttb_pkg::TIME_BITS-1:0]  tick_ff, tick_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           ok_ff;
   logic [ttb_pkg::INDEX_BITS-1:0] slot_ff;
   logic [ttb_pkg::FLAG_BITS-1:0]  flags_ff;
   logic [ttb_pkg::TIME_BITS-1:0]  time_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign cmd.fire       = accept;
   assign cmd.command    = ttb_pkg::command_type'(req_tuser);
   assign cmd.slot_index = req_tdata[3:0];
   assign cmd.limit      = req_tdata[19:4];
   assign cmd.start_now  = req_tdata[20];

   assign free_chain[0] = 1'b0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      ttb_cell #(
         .INDEX      (i),
         .LIMIT_BITS (LIMIT_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .free_before  (free_chain[i]),
         .free_through (free_chain[i+1]),
         .status       (status[i])
      );
   end

   always_comb begin
      grant_index = '0;
      remove_ok   = 1'b0;
      flags_next  = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (status[i].grant) grant_index = grant_index | ttb_pkg::INDEX_BITS'(i);
         remove_ok = remove_ok | status[i].remove_hit;
      end
      for (int i = 0; i < FLAG_SLOTS; i++) begin
         flags_next[i] = status[i].expired_next;
      end
   end

   always_comb begin
      ok_next   = 1'b0;
      slot_next = cmd.slot_index;
      tick_in   = tick_ff;
      case (cmd.command)
         ttb_pkg::CMD_TICK:   tick_in = tick_ff + ttb_pkg::TIME_BITS'(1);
         ttb_pkg::CMD_ADD: begin
            ok_next = free_chain[SLOTS];
            if (free_chain[SLOTS]) slot_next = grant_index;
         end
         ttb_pkg::CMD_REMOVE: ok_next = remove_ok;
         ttb_pkg::CMD_RESTART: ok_next = 1'b0;
         default: ;
      endcase
   end

   assign rsp_valid_in = accept ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) tick_ff <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff    <= ok_next;
         slot_ff  <= slot_next;
         flags_ff <= flags_next;
         time_ff  <= tick_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, time_ff, flags_ff, slot_ff, ok_ff};

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the timeout timer bank: command stream, result checks, summary.
module testbench;

   localparam int NUM_SLOTS = ttb_pkg::SLOTS_DEFAULT;
   localparam int LIMIT_W   = ttb_pkg::LIMIT_BITS_DEFAULT;

   typedef struct packed {
      ttb_pkg::command_type              command;
      logic [ttb_pkg::INDEX_BITS-1:0]    slot_index;
      logic [ttb_pkg::IN_LIMIT_BITS-1:0] limit;
      logic                              start_now;
   } timer_cmd_type;

   typedef struct packed {
      logic                           ok;
      logic [ttb_pkg::INDEX_BITS-1:0] slot_out;
      logic [ttb_pkg::FLAG_BITS-1:0]  expired_flags;
      logic [ttb_pkg::TIME_BITS-1:0]  time_now;
   } bank_status_type;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [ttb_pkg::REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic [1:0]                        req_tuser  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [ttb_pkg::RSP_DATA_BITS-1:0] rsp_tdata;

   timeout_timer_bank_unit #(
      .SLOTS      (NUM_SLOTS),
      .LIMIT_BITS (LIMIT_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted bank state
   logic                          bank_valid   [NUM_SLOTS];
   logic [LIMIT_W-1:0]            bank_limit   [NUM_SLOTS];
   logic [LIMIT_W:0]              bank_count   [NUM_SLOTS];
   logic                          bank_running [NUM_SLOTS];
   logic                          bank_expired [NUM_SLOTS];
   logic [ttb_pkg::TIME_BITS-1:0] bank_ticks;

   timer_cmd_type   pending_commands [$];
   bank_status_type predicted_status [$];
   timer_cmd_type   offered_cmd;
   timer_cmd_type   next_cmd;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   logic rx_hold      = 1'b0;

   int fault_count   = 0;
   int results_seen  = 0;
   int cmd_count [4] = '{0, 0, 0, 0};
   int refused_adds  = 0;
   int expiry_total  = 0;

   function automatic bank_status_type apply_command(timer_cmd_type c);
      bank_status_type    r;
      logic               found;
      logic [LIMIT_W-1:0] lim;
      r.ok       = 1'b0;
      r.slot_out = c.slot_index;
      found      = 1'b0;
      lim        = LIMIT_W'(c.limit);
      cmd_count[int'(c.command)]++;
      case (c.command)
         ttb_pkg::CMD_TICK: begin
            bank_ticks = bank_ticks + 1'b1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (bank_valid[i] && bank_limit[i] != '0) begin
                  if (bank_count[i] == '0) bank_running[i] = 1'b1;
                  if (bank_running[i]) begin
                     bank_count[i] = bank_count[i] + 1'b1;
                     if (bank_count[i] > {1'b0, bank_limit[i]}) begin
                        bank_expired[i] = 1'b1;
                        bank_running[i] = 1'b0;
                        expiry_total++;
                     end
                  end
               end
            end
         end
         ttb_pkg::CMD_ADD: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!found && !bank_valid[i]) begin
                  found           = 1'b1;
                  bank_valid[i]   = 1'b1;
                  bank_limit[i]   = (lim != '0) ? lim : LIMIT_W'(ttb_pkg::DEFAULT_LIMIT);
                  bank_expired[i] = 1'b0;
                  bank_count[i]   = {1'b0, lim};
                  bank_running[i] = c.start_now;
                  r.ok            = 1'b1;
                  r.slot_out      = ttb_pkg::INDEX_BITS'(i);
               end
            end
            if (!found) refused_adds++;
         end
         ttb_pkg::CMD_REMOVE: begin
            if (int'(c.slot_index) < NUM_SLOTS && bank_valid[c.slot_index]) begin
               bank_valid[c.slot_index] = 1'b0;
               r.ok = 1'b1;
            end
         end
         default: begin
            // restart works on invalid slots too, running is left alone
            if (int'(c.slot_index) < NUM_SLOTS) begin
               bank_count[c.slot_index]   = '0;
               bank_expired[c.slot_index] = 1'b0;
            end
         end
      endcase
      r.expired_flags = '0;
      for (int i = 0; i < NUM_SLOTS && i < ttb_pkg::FLAG_BITS; i++)
         r.expired_flags[i] = bank_expired[i];
      r.time_now = bank_ticks;
      return r;
   endfunction

   function automatic timer_cmd_type make_cmd(ttb_pkg::command_type cmd,
                                              logic [ttb_pkg::INDEX_BITS-1:0] idx,
                                              logic [ttb_pkg::IN_LIMIT_BITS-1:0] lim,
                                              logic start);
      timer_cmd_type c;
      c.command    = cmd;
      c.slot_index = idx;
      c.limit      = lim;
      c.start_now  = start;
      return c;
   endfunction

   // mostly small limits so that counting slots actually reach expiry
   function automatic timer_cmd_type random_command();
      int                                pick;
      int                                lsel;
      ttb_pkg::command_type              cmd;
      logic [ttb_pkg::IN_LIMIT_BITS-1:0] lim;
      pick = $urandom_range(99);
      if (pick < 45)      cmd = ttb_pkg::CMD_TICK;
      else if (pick < 65) cmd = ttb_pkg::CMD_ADD;
      else if (pick < 80) cmd = ttb_pkg::CMD_REMOVE;
      else                cmd = ttb_pkg::CMD_RESTART;
      lsel = $urandom_range(9);
      if (lsel < 7)      lim = ttb_pkg::IN_LIMIT_BITS'($urandom_range(7));
      else if (lsel < 9) lim = ttb_pkg::IN_LIMIT_BITS'($urandom_range(63));
      else               lim = ttb_pkg::IN_LIMIT_BITS'($urandom_range(65535));
      return make_cmd(cmd, ttb_pkg::INDEX_BITS'($urandom_range(15)), lim,
                      1'($urandom_range(1)));
   endfunction

   task automatic queue_random(int n);
      int k;
      int burst;
      k = 0;
      while (k < n) begin
         if ($urandom_range(9) == 0) begin
            // run of ticks to carry restarted slots through to expiry
            burst = $urandom_range(8, 3);
            repeat (burst) begin
               pending_commands.push_back(make_cmd(ttb_pkg::CMD_TICK,
                                                   ttb_pkg::INDEX_BITS'($urandom_range(15)),
                                                   ttb_pkg::IN_LIMIT_BITS'($urandom),
                                                   1'($urandom_range(1))));
            end
            k += burst;
         end else begin
            pending_commands.push_back(random_command());
            k++;
         end
      end
   endtask

   task automatic drain();
      while (pending_commands.size() != 0 || req_tvalid || predicted_status.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want)
         note_fault($sformatf("result %0d %s: expected %h, got %h", results_seen, name, want, got));
   endtask

   task automatic check_status();
      bank_status_type want;
      bank_status_type got;
      got.ok            = rsp_tdata[0];
      got.slot_out      = rsp_tdata[4:1];
      got.expired_flags = rsp_tdata[20:5];
      got.time_now      = rsp_tdata[52:21];
      results_seen++;
      if (predicted_status.size() == 0) begin
         note_fault($sformatf("result %0d with no command outstanding: %h",
                              results_seen, rsp_tdata));
      end else begin
         want = predicted_status.pop_front();
         check_field("ok", 32'(want.ok), 32'(got.ok));
         check_field("slot_out", 32'(want.slot_out), 32'(got.slot_out));
         check_field("expired_flags", 32'(want.expired_flags), 32'(got.expired_flags));
         check_field("time_now", want.time_now, got.time_now);
      end
   endtask

   // driver: one transaction offered at a time, prediction taken on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predicted_status.push_back(apply_command(offered_cmd));
         if (!req_tvalid || req_tready) begin
            if (pending_commands.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_cmd    = pending_commands.pop_front();
               offered_cmd <= next_cmd;
               req_tdata   <= {{(ttb_pkg::REQ_DATA_BITS-21){1'b0}}, next_cmd.start_now,
                               next_cmd.limit, next_cmd.slot_index};
               req_tuser   <= next_cmd.command;
               req_tvalid  <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_status();
         rsp_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         bank_valid[i]   = 1'b0;
         bank_limit[i]   = LIMIT_W'(ttb_pkg::RESET_LIMIT);
         bank_count[i]   = '0;
         bank_running[i] = 1'b0;
         bank_expired[i] = 1'b0;
      end
      bank_ticks = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty bank, zero and full limits, fill to full, refused add, reuse
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_TICK, 4'd0, 16'd0, 1'b0));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_REMOVE, 4'd0, 16'hFFFF, 1'b1));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_RESTART, 4'd15, 16'd0, 1'b0));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_ADD, 4'd15, 16'd0, 1'b0));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_ADD, 4'd0, 16'hFFFF, 1'b1));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_ADD, 4'd7, 16'd1, 1'b1));
      for (int i = 3; i < NUM_SLOTS; i++)
         pending_commands.push_back(make_cmd(ttb_pkg::CMD_ADD, ttb_pkg::INDEX_BITS'(i),
                                             16'd2, 1'(i & 1)));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_ADD, 4'd9, 16'd4, 1'b1));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_TICK, 4'd15, 16'hFFFF, 1'b1));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_TICK, 4'd0, 16'd0, 1'b0));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_REMOVE, 4'd5, 16'd0, 1'b0));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_ADD, 4'd0, 16'h5A5A, 1'b0));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_RESTART, 4'd1, 16'hA5A5, 1'b1));
      pending_commands.push_back(make_cmd(ttb_pkg::CMD_TICK, 4'd10, 16'd3, 1'b0));
      drain();

      send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(130);  drain();
      send_idle_pct = 48; recv_stall_pct = 0;  queue_random(130);  drain();
      send_idle_pct = 0;  recv_stall_pct = 48; queue_random(130);  drain();
      send_idle_pct = 19; recv_stall_pct = 19; queue_random(130);  drain();

      // long receiver hold-off while the sender keeps offering
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random(40);
      rx_hold = 1'b1;
      repeat (200) @(negedge clock);
      rx_hold = 1'b0;
      drain();

      $display("checked %0d results: %0d ticks, %0d adds (%0d refused, bank full),",
               results_seen, cmd_count[0], cmd_count[1], refused_adds);
      $display("%0d removes, %0d restarts, slot expiries seen: %0d, mismatches: %0d",
               cmd_count[2], cmd_count[3], expiry_total, fault_count);
      if (fault_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout: %0d commands still queued, %0d results outstanding",
               pending_commands.size(), predicted_status.size());
      $display("status: fail");
      $finish;
   end

endmodule
